[rtl/letter_multiset_dominance_filter_top_macros.svh]
// assertion helpers used by the top level of the rtl
`ifndef LETTER_MULTISET_DOMINANCE_FILTER_TOP_MACROS_SVH
`define LETTER_MULTISET_DOMINANCE_FILTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// pre holds, so post holds in the same cycle
`define LMDF_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// cond never holds
`define LMDF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define LMDF_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`define LMDF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[rtl/lmdf_pkg.sv]
`default_nettype none
package lmdf_pkg;

    localparam int LETTERS = 26;
    localparam int COUNT_W = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_Z = 8'h7a;
    localparam int MIN_LEN_W = 5;
    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 5'd3;

    typedef logic [LETTERS-1:0][COUNT_W-1:0] tally_t;

    typedef enum logic [2:0] {
        STATUS_STORED  = 3'd0,
        STATUS_COVERED = 3'd1,
        STATUS_INVALID = 3'd2,
        STATUS_LONG    = 3'd3,
        STATUS_SHORT   = 3'd4,
        STATUS_FULL    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } ctrl_state_t;

    // error flags of the word being tallied
    typedef struct packed {
        logic too_long;
        logic invalid;
    } word_flags_t;

    // search token that walks along the row of cells
    typedef struct packed {
        logic valid;
        logic found;
    } token_t;

endpackage
`default_nettype wire

[rtl/letter_multiset_dominance_filter_top.sv]
// timing: a word rejected on flags or length has its result registered in the cycle after
//   its last item; a checked word passes the start register, the token registers of the
//   MAX_ENTRIES cells and the done state, where it waits for a free output register
// throughput: one character per cycle while idle; input stalls while a word is checked
// reset: aresetn synchronous, active low; clears the word tally, the entry count,
//   the output item and sets min_word_length to 3; stored entries are left as they are
`default_nettype none
`include "letter_multiset_dominance_filter_top_macros.svh"
module letter_multiset_dominance_filter_top
    import lmdf_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_WORD_LEN = 31
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // character items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last_char
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [5:0] entry_index, [12:6] entries_held, rest zero
    output logic [2:0]       m_tuser,   // [2:0] status
    // min_word_length register
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = $clog2(MAX_WORD_LEN + 1);

    // control
    ctrl_state_t state_reg, state_next;
    logic [MIN_LEN_W-1:0] min_len_reg;
    logic [CW-1:0] used_reg;
    logic start_reg;
    logic found_reg;
    logic [IW-1:0] hit_idx_reg;

    // output item register
    logic       m_valid_reg;
    status_t    status_reg, status_next;
    logic [5:0] index_reg, index_next;
    logic [6:0] held_reg, held_next;

    logic s_acc, out_free, load_out, take, clear, wr_en, needs_search;
    logic used_inc;
    status_t early_status;

    // tally front end
    tally_t      word_tally;
    logic [LW-1:0] len_next;
    word_flags_t flags_next;

    // row of cells
    token_t        chain_tok [MAX_ENTRIES+1];
    logic [IW-1:0] chain_idx [MAX_ENTRIES+1];

    // width helpers for masking to the output fields
    logic [IW+5:0]  hit_idx_ext, used_idx_ext;
    logic [CW+6:0]  used_ext, used_inc_ext;
    logic [LW+MIN_LEN_W-1:0] len_ext, min_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= MIN_LEN_RESET;
        end else if (cfg_valid) begin
            min_len_reg <= cfg_data;
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    // a last item also needs room for its result; other items wait only while a word is checked
    assign s_tready = (state_reg == ST_IDLE) && (!s_tlast || out_free);
    assign s_acc    = s_tvalid && s_tready;

    lmdf_tally #(
        .MAX_WORD_LEN(MAX_WORD_LEN),
        .LW(LW)
    ) u_tally (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .char_code (s_tdata),
        .take      (take),
        .clear     (clear),
        .tally_q   (word_tally),
        .len_next  (len_next),
        .flags_next(flags_next)
    );

    assign len_ext = {{MIN_LEN_W{1'b0}}, len_next};
    assign min_ext = {{LW{1'b0}}, min_len_reg};

    // word-end checks that need no lookup, in priority order
    always_comb begin
        needs_search = 1'b0;
        early_status = STATUS_STORED;
        if (flags_next.invalid) begin
            early_status = STATUS_INVALID;
        end else if (flags_next.too_long) begin
            early_status = STATUS_LONG;
        end else if (len_ext < min_ext) begin
            early_status = STATUS_SHORT;
        end else begin
            needs_search = 1'b1;
        end
    end

    // search token enters the first cell
    assign chain_tok[0] = '{valid: start_reg, found: 1'b0};
    assign chain_idx[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            lmdf_cell #(
                .CELL_IDX(g),
                .IW(IW),
                .CW(CW)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_tok    (chain_tok[g]),
                .in_idx    (chain_idx[g]),
                .out_tok   (chain_tok[g+1]),
                .out_idx   (chain_idx[g+1]),
                .used      (used_reg),
                .word_tally(word_tally),
                .wr_en     (wr_en),
                .wr_addr   (used_reg[IW-1:0])
            );
        end
    endgenerate

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tlast && needs_search) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (chain_tok[MAX_ENTRIES].valid) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign hit_idx_ext  = {6'b0, hit_idx_reg};
    assign used_idx_ext = {6'b0, used_reg[IW-1:0]};
    assign used_ext     = {7'b0, used_reg};
    assign used_inc_ext = {7'b0, used_reg + CW'(1)};

    // outputs of the controller
    always_comb begin
        take        = 1'b0;
        clear       = 1'b0;
        load_out    = 1'b0;
        wr_en       = 1'b0;
        used_inc    = 1'b0;
        status_next = early_status;
        index_next  = 6'd0;
        held_next   = used_ext[6:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tlast && !needs_search) begin
                        // rejected on its flags or its length, result at once
                        clear    = 1'b1;
                        load_out = 1'b1;
                    end else begin
                        take = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
            end
            ST_DONE: begin
                if (out_free) begin
                    clear    = 1'b1;
                    load_out = 1'b1;
                    if (found_reg) begin
                        status_next = STATUS_COVERED;
                        index_next  = hit_idx_ext[5:0];
                    end else if (used_reg == CW'(MAX_ENTRIES)) begin
                        status_next = STATUS_FULL;
                    end else begin
                        status_next = STATUS_STORED;
                        index_next  = used_idx_ext[5:0];
                        held_next   = used_inc_ext[6:0];
                        wr_en       = 1'b1;
                        used_inc    = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= (state_reg == ST_IDLE) && (state_next == ST_SEARCH);
            if (used_inc) begin
                used_reg <= used_reg + CW'(1);
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (chain_tok[MAX_ENTRIES].valid) begin
            found_reg   <= chain_tok[MAX_ENTRIES].found;
            hit_idx_reg <= chain_idx[MAX_ENTRIES];
        end
        if (load_out) begin
            status_reg <= status_next;
            index_reg  <= index_next;
            held_reg   <= held_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, held_reg, index_reg};
    assign m_tuser  = status_reg;

    `LMDF_ASSERT_NEVER(a_used_bound, aclk, aresetn, used_reg > CW'(MAX_ENTRIES),
        "entry count beyond table size")
    `LMDF_ASSERT_IMPL(a_write_done, aclk, aresetn, wr_en,
        (state_reg == ST_DONE) && (used_reg < CW'(MAX_ENTRIES)), "entry write outside word end")
    `LMDF_ASSERT_IMPL(a_busy_stall, aclk, aresetn, state_reg != ST_IDLE, !s_tready,
        "input taken during search")
    `LMDF_ASSERT_IMPL(a_token_search, aclk, aresetn, chain_tok[MAX_ENTRIES].valid,
        state_reg == ST_SEARCH, "search token outside search")
    `LMDF_ASSERT_IMPL(a_load_free, aclk, aresetn, load_out, out_free,
        "result overwrites waiting item")

endmodule
`default_nettype wire

[rtl/lmdf_tally.sv]
`default_nettype none
module lmdf_tally
    import lmdf_pkg::*;
#(
    parameter int MAX_WORD_LEN = 31,
    parameter int LW = 5
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [7:0]    char_code,
    input  wire logic          take,
    input  wire logic          clear,
    output tally_t             tally_q,
    output logic [LW-1:0]      len_next,
    output word_flags_t        flags_next
);

    tally_t      tally_reg, tally_next;
    logic [LW-1:0] len_reg;
    word_flags_t flags_reg;
    logic        is_letter;

    assign is_letter = (char_code >= CHAR_A) && (char_code <= CHAR_Z);

    always_comb begin
        tally_next = tally_reg;
        flags_next = flags_reg;
        len_next   = len_reg;
        if (len_reg >= LW'(MAX_WORD_LEN)) begin
            flags_next.too_long = 1'b1;
        end else begin
            len_next = len_reg + LW'(1);
        end
        if (!is_letter) begin
            flags_next.invalid = 1'b1;
        end
        for (int i = 0; i < LETTERS; i++) begin
            if (is_letter && (char_code == CHAR_A + 8'(i))) begin
                if (tally_reg[i] == COUNT_MAX) begin
                    flags_next.too_long = 1'b1;
                end else begin
                    tally_next[i] = tally_reg[i] + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            tally_reg <= '0;
            len_reg   <= '0;
            flags_reg <= '0;
        end else if (take) begin
            tally_reg <= tally_next;
            len_reg   <= len_next;
            flags_reg <= flags_next;
        end
    end

    assign tally_q = tally_reg;

endmodule
`default_nettype wire

[rtl/lmdf_cell.sv]
`default_nettype none
module lmdf_cell
    import lmdf_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int IW = 6,
    parameter int CW = 7
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire token_t        in_tok,
    input  wire logic [IW-1:0] in_idx,
    output token_t             out_tok,
    output logic [IW-1:0]      out_idx,
    input  wire logic [CW-1:0] used,
    input  wire tally_t        word_tally,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr
);

    tally_t entry_reg;
    token_t tok_reg;
    logic [IW-1:0] idx_reg;
    logic covers, hit;

    // entry dominated letter by letter by the word
    always_comb begin
        covers = 1'b1;
        for (int i = 0; i < LETTERS; i++) begin
            if (entry_reg[i] > word_tally[i]) begin
                covers = 1'b0;
            end
        end
    end

    assign hit = in_tok.valid && !in_tok.found && (CW'(CELL_IDX) < used) && covers;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg.valid <= in_tok.valid;
            tok_reg.found <= in_tok.found || hit;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= hit ? IW'(CELL_IDX) : in_idx;
        if (wr_en && (wr_addr == IW'(CELL_IDX))) begin
            entry_reg <= word_tally;
        end
    end

    assign out_tok = tok_reg;
    assign out_idx = idx_reg;

endmodule
`default_nettype wire

[sim/word_verdict_check.sv]
`default_nettype none
module word_verdict_check
    import lmdf_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_WORD_LEN = 31
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last_char
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [5:0] entry_index, [12:6] entries_held, rest zero
    input  wire logic [2:0]  m_tuser,   // [2:0] status
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [4:0]  cfg_data,
    output int               words_pending,
    output int               mismatch_total
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t    status;
        logic [5:0] slot;
        logic [6:0] held;
    } verdict_t;

    tally_t      held_tallies [MAX_ENTRIES];
    int          held_count = 0;
    tally_t      word_counts;
    int          word_len;
    word_flags_t word_flags;
    logic [4:0]  min_len;
    verdict_t    awaited [$];
    int          queue_len = 0;
    int          fails = 0;

    assign words_pending  = queue_len;
    assign mismatch_total = fails;

    task automatic log_mismatch(input string what);
        fails++;
        if (fails <= 100)
            $display("%0t ns word result mismatch: %s", $time, what);
    endtask

    task automatic clear_word();
        word_counts = '0;
        word_len    = 0;
        word_flags  = '0;
    endtask

    // adds one character to the word and judges the word at its last one
    task automatic tally_char(input logic [7:0] code, input logic last);
        verdict_t v;
        int       k;
        int       e;
        int       i;
        bit       hit;
        if (word_len >= MAX_WORD_LEN)
            word_flags.too_long = 1'b1;
        else
            word_len++;
        if (code >= CHAR_A && code <= CHAR_Z) begin
            k = int'(code - CHAR_A);
            if (word_counts[k] >= COUNT_MAX)
                word_flags.too_long = 1'b1;
            else
                word_counts[k] = word_counts[k] + 1'b1;
        end else begin
            word_flags.invalid = 1'b1;
        end
        if (!last)
            return;

        v.slot = '0;
        if (word_flags.invalid) begin
            v.status = STATUS_INVALID;
        end else if (word_flags.too_long) begin
            v.status = STATUS_LONG;
        end else if (word_len < int'(min_len)) begin
            v.status = STATUS_SHORT;
        end else begin
            v.status = STATUS_STORED;
            hit = 1'b0;
            // lowest entry whose every count is at or below the word's
            for (e = 0; e < held_count && !hit; e++) begin
                hit = 1'b1;
                for (i = 0; i < LETTERS; i++)
                    if (held_tallies[e][i] > word_counts[i])
                        hit = 1'b0;
                if (hit) begin
                    v.status = STATUS_COVERED;
                    v.slot   = 6'(e);
                end
            end
            if (!hit) begin
                if (held_count >= MAX_ENTRIES) begin
                    v.status = STATUS_FULL;
                end else begin
                    v.slot = 6'(held_count);
                    held_tallies[held_count] = word_counts;
                    held_count++;
                end
            end
        end
        v.held = 7'(held_count);
        awaited.push_back(v);
        clear_word();
    endtask

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            held_count = 0;
            min_len    = MIN_LEN_RESET;
            clear_word();
            awaited.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                min_len = cfg_data;
            // results first, so a word closing on this edge cannot be matched early
            if (m_tvalid && m_tready) begin
                if (awaited.size() == 0) begin
                    log_mismatch($sformatf("result with no word waiting, status %0d", m_tuser));
                end else begin
                    want = awaited.pop_front();
                    if (m_tuser !== want.status)
                        log_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
                    if (m_tdata[5:0] !== want.slot)
                        log_mismatch($sformatf("entry_index %0d, expected %0d",
                                               m_tdata[5:0], want.slot));
                    if (m_tdata[12:6] !== want.held)
                        log_mismatch($sformatf("entries_held %0d, expected %0d",
                                               m_tdata[12:6], want.held));
                    if (m_tdata[15:13] !== 3'b000)
                        log_mismatch($sformatf("padding bits %b", m_tdata[15:13]));
                end
            end
            if (s_tvalid && s_tready)
                tally_char(s_tdata, s_tlast);
        end
        queue_len <= awaited.size();
    end

endmodule
`default_nettype wire

[sim/letter_multiset_dominance_filter_top_tb.sv]
`default_nettype none
module letter_multiset_dominance_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lmdf_pkg::*;

    localparam int ENTRY_SLOTS     = 64;
    localparam int WORD_LIMIT      = 31;
    // a checked word walks the whole row of cells, plus some margin
    localparam int SETTLE_CYCLES   = ENTRY_SLOTS + 16;
    localparam int HOLD_OFF_CYCLES = 400;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // [7:0] char_code
    logic        s_tlast   = 1'b0;  // last_char
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // [5:0] entry_index, [12:6] entries_held, rest zero
    logic [2:0]  m_tuser;           // [2:0] status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data  = '0;

    int          words_pending;
    int          mismatch_total;

    // idling switches per phase, and the request for one long receiver hold-off
    bit          send_idle;
    bit          ready_idle;
    bit          hold_req;
    int          items_sent;
    logic [4:0]  min_len_now;
    // letter-only words already sent, reused to build covered words
    string       word_pool [$];

    letter_multiset_dominance_filter_top #(
        .MAX_ENTRIES  (ENTRY_SLOTS),
        .MAX_WORD_LEN (WORD_LIMIT)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    word_verdict_check #(
        .MAX_ENTRIES  (ENTRY_SLOTS),
        .MAX_WORD_LEN (WORD_LIMIT)
    ) u_verdict_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .words_pending  (words_pending),
        .mismatch_total (mismatch_total)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("letter_multiset_dominance_filter_top_tb: done, errors");
        $finish;
    end

    // one character item, after a random gap when the sender idles
    task automatic send_char(input logic [7:0] code, input logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= code;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        items_sent++;
    endtask

    task automatic send_letters(input string w);
        int i;
        for (i = 0; i < w.len(); i++)
            send_char(w[i], i == w.len() - 1);
    endtask

    // n letters drawn from the first span letters of the alphabet
    function automatic string random_letters(input int n, input int span);
        string w;
        int    i;
        w = "";
        for (i = 0; i < n; i++)
            w = $sformatf("%s%c", w, CHAR_A + 8'($urandom_range(0, span - 1)));
        return w;
    endfunction

    // stop offering and wait until every word has had its result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_pending != 0);
    endtask

    // register writes only once the block has gone quiet
    task automatic set_min_len(input logic [4:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid   <= 1'b0;
        min_len_now = value;
    endtask

    // whole words until about count more items have gone in
    task automatic run_random(input int count);
        int         stop_at;
        int         pick;
        int         lo;
        int         n;
        int         i;
        int         bad_at;
        bit         mixed;
        logic [7:0] same;
        string      w;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            lo   = (min_len_now > 1) ? int'(min_len_now) : 1;
            if (pick < 45 || word_pool.size() == 0) begin
                // fresh word at or a little above the minimum, now and then a narrow alphabet
                n = $urandom_range(lo, (lo + 4 > WORD_LIMIT) ? WORD_LIMIT : lo + 4);
                w = random_letters(n, ($urandom_range(0, 3) == 0) ? 6 : 26);
                if (word_pool.size() < 200)
                    word_pool.push_back(w);
                send_letters(w);
            end else if (pick < 65) begin
                // earlier word with letters added around it, so usually covered
                w = word_pool[$urandom_range(0, word_pool.size() - 1)];
                n = WORD_LIMIT - w.len();
                if (n > 4)
                    n = 4;
                n = $urandom_range(0, n);
                w = {random_letters(n / 2, 26), w, random_letters(n - n / 2, 26)};
                send_letters(w);
            end else if (pick < 75) begin
                // exact repeat of an earlier word
                send_letters(word_pool[$urandom_range(0, word_pool.size() - 1)]);
            end else if (pick < 83) begin
                // below the minimum length
                n = (lo > 1) ? $urandom_range(1, lo - 1) : 1;
                send_letters(random_letters(n, 26));
            end else if (pick < 89) begin
                // overlong: one letter repeated past its count limit, or mixed letters,
                // sometimes with a bad character so that invalid wins over too long
                n      = $urandom_range(WORD_LIMIT + 1, WORD_LIMIT + 9);
                mixed  = $urandom_range(0, 1);
                same   = CHAR_A + 8'($urandom_range(0, 25));
                bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
                for (i = 0; i < n; i++) begin
                    if (i == bad_at)
                        send_char(8'($urandom_range(CHAR_Z + 1, 255)), i == n - 1);
                    else if (mixed)
                        send_char(CHAR_A + 8'($urandom_range(0, 25)), i == n - 1);
                    else
                        send_char(same, i == n - 1);
                end
            end else if (pick < 93) begin
                // exactly the longest legal word; with a span of one letter it reaches the top count
                send_letters(random_letters(WORD_LIMIT, $urandom_range(1, 26)));
            end else begin
                // noise over the full character range
                n = $urandom_range(1, 40);
                for (i = 0; i < n; i++)
                    send_char(8'($urandom_range(0, 255)), i == n - 1);
            end
        end
    endtask

    // result side: random stalls per item, one long hold-off on request
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = ready_idle ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin : stimulus
        items_sent  = 0;
        min_len_now = MIN_LEN_RESET;
        send_idle   = 1'b1;
        ready_idle  = 1'b1;
        hold_req    = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words at the reset minimum of three
        send_letters("ab");                     // too short
        send_letters("abc");                    // first entry, slot 0
        send_letters("cab");                    // same letters, covered by slot 0
        send_letters("zzz");                    // top letter, slot 1
        send_char(CHAR_A - 8'd1, 1'b0);         // just below a
        send_char(CHAR_A, 1'b0);
        send_char(CHAR_Z + 8'd1, 1'b1);         // just above z, invalid
        send_char(8'hff, 1'b0);                 // invalid, none of the bytes is a letter
        send_char(8'h80, 1'b0);
        send_char(8'h00, 1'b1);
        send_letters("q");                      // single character word
        send_letters("zazyx");                  // neither entry covers it

        // table fills here; the receiver holds off once while words keep coming
        set_min_len(5'd5);
        run_random(150);
        hold_req = 1'b1;
        run_random(300);

        // top of the range, sender idling only
        set_min_len(5'd31);
        ready_idle = 1'b0;
        run_random(250);

        // no idling on either side
        set_min_len(5'd12);
        send_idle = 1'b0;
        run_random(250);

        // one-letter words pass; the sender waits once for every result mid-phase
        set_min_len(5'd1);
        ready_idle = 1'b1;
        run_random(125);
        wait_drained();
        run_random(125);

        // zero rejects nothing on length
        set_min_len(5'd0);
        send_idle = 1'b1;
        run_random(200);

        set_min_len(5'($urandom_range(2, 30)));
        run_random(400);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_total == 0) begin
            $display("letter_multiset_dominance_filter_top_tb: done, clean");
        end else begin
            $display("letter_multiset_dominance_filter_top_tb: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
